FILE: rtl/ansa_pkg.sv
package ansa_pkg;

    typedef struct packed {
        logic signed [31:0] start_value;
        logic signed [31:0] stop_value;
        logic [9:0]         requested_intervals;
    } in_t;

    typedef struct packed {
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
        logic [11:0]        interval_count;
        logic [3:0]         step_mantissa;
        logic [3:0]         step_exponent;
        logic               degenerate;
        logic               step_floor_hit;
    } out_t;

    localparam logic [2:0] REG_MANT_COUNT  = 3'd0;
    localparam logic [2:0] REG_MANT_SECOND = 3'd1;
    localparam logic [2:0] REG_MANT_THIRD  = 3'd2;
    localparam logic [2:0] REG_MANT_FOURTH = 3'd3;

    localparam int POW_BITS  = 34;
    localparam int PROD_BITS = 38;

    function automatic logic [POW_BITS-1:0] pow10(input logic [3:0] n);
        logic [POW_BITS-1:0] r;
        unique case (n)
            4'd0:    r = 34'd1;
            4'd1:    r = 34'd10;
            4'd2:    r = 34'd100;
            4'd3:    r = 34'd1000;
            4'd4:    r = 34'd10000;
            4'd5:    r = 34'd100000;
            4'd6:    r = 34'd1000000;
            4'd7:    r = 34'd10000000;
            4'd8:    r = 34'd100000000;
            default: r = 34'd1000000000;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/axis_nice_step_autoscaler.sv
// Nice-step axis autoscaler.
// Input channel in_valid/in_stall/in_data carries a range and a wanted
// interval count; one result transfer per input on out_valid/out_stall/out_data.
// Mantissa table is set through cfg_we/cfg_index/cfg_data; the user must
// set it only while idle, as the block does not enforce this. One item at a
// time: in_stall is high from acceptance until the result is in the output
// register. A zero-width range skips the search; otherwise an exponent search
// and a mantissa search run, then each candidate step divides both bounds on
// one shared restoring divider (one quotient bit a cycle). Candidates are at
// most 1+(number of refinements). A new item may be accepted while a result
// still waits in the output register; the finished result then waits until
// that register empties. Out_stall holds the result and its valid. Reset
// clears the sequencer and output valid, and returns the table to 1, 2, 5, 9
// with three entries in use.
module axis_nice_step_autoscaler #(
    parameter int VALUE_BITS    = 32,
    parameter int MAX_MANTISSAS = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  ansa_pkg::in_t in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output ansa_pkg::out_t out_data,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [3:0]    cfg_data
);

    localparam int VB = VALUE_BITS;
    localparam int EW = VB + 4;
    localparam int CW = $clog2(VB + 1);
    localparam logic [2:0] MAXM = 3'(MAX_MANTISSAS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_NSRCH = 3'd1;
    localparam logic [2:0] S_ISRCH = 3'd2;
    localparam logic [2:0] S_STEP  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_POST  = 3'd5;
    localparam logic [2:0] S_EVAL  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0] cnt_cfg_reg;
    logic [3:0] m2_reg, m3_reg, m4_reg;

    logic [2:0] state_reg;
    logic signed [VB-1:0] lo_reg, hi_reg;
    logic [9:0]    req_reg;
    logic [VB-1:0] width_reg;
    logic [3:0]    n_reg;
    logic [1:0]    idx_reg;
    logic [VB-1:0] step_reg;
    logic          first_reg, pass_reg, neg_reg;
    logic [CW-1:0] cnt_reg;
    logic [VB:0]   rem_reg;
    logic [VB-1:0] dvd_reg;
    logic signed [EW-1:0] flh_reg, cll_reg;
    logic signed [VB-1:0] highv_reg, lowv_reg;
    logic signed [VB-1:0] p_low_reg, p_high_reg;
    logic signed [EW-1:0] p_ival_reg;
    logic [3:0]    p_mant_reg, p_n_reg;
    ansa_pkg::out_t res_reg;
    logic          out_valid_reg;
    ansa_pkg::out_t out_data_reg;

    logic [2:0] used;
    logic [1:0] last_idx;
    logic [3:0] mant;
    logic [ansa_pkg::PROD_BITS-1:0] prod;
    logic [ansa_pkg::PROD_BITS-1:0] width_x;
    logic signed [VB-1:0] in_a, in_b;
    logic signed [VB:0]   diff;
    logic [VB:0]   rem_sh;
    logic          qbit;
    logic signed [VB-1:0] xsel;
    logic signed [EW-1:0] qx, rx, sx, xx, rnz;
    logic signed [EW-1:0] ival, reqx;
    logic out_free;

    always_comb
    begin
        used = cnt_cfg_reg;
        if (used == 3'd0)
            used = 3'd1;
        if (used > MAXM)
            used = MAXM;
        last_idx = 2'(used - 3'd1);
        unique case (idx_reg)
            2'd0:    mant = 4'd1;
            2'd1:    mant = (m2_reg < 4'd2) ? 4'd2 : m2_reg;
            2'd2:    mant = (m3_reg < 4'd2) ? 4'd2 : m3_reg;
            default: mant = (m4_reg < 4'd2) ? 4'd2 : m4_reg;
        endcase
        prod    = ansa_pkg::PROD_BITS'(mant) * ansa_pkg::PROD_BITS'(ansa_pkg::pow10(n_reg));
        width_x = ansa_pkg::PROD_BITS'(width_reg);
    end

    assign in_a = in_data.start_value[VB-1:0];
    assign in_b = in_data.stop_value[VB-1:0];
    assign diff = (VB+1)'(in_b) - (VB+1)'(in_a);

    assign rem_sh = {rem_reg[VB-1:0], dvd_reg[VB-1]};
    assign qbit   = (rem_sh >= {1'b0, step_reg});

    always_comb
    begin
        xsel = pass_reg ? lo_reg : hi_reg;
        qx   = signed'(EW'(dvd_reg));
        rx   = signed'(EW'(rem_reg[VB-1:0]));
        sx   = signed'(EW'(step_reg));
        xx   = EW'(xsel);
        rnz  = (rem_reg != '0) ? EW'(1) : EW'(0);
        ival = flh_reg - cll_reg;
        reqx = signed'(EW'(req_reg));
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_cfg_reg <= 3'd3;
            m2_reg      <= 4'd2;
            m3_reg      <= 4'd5;
            m4_reg      <= 4'd9;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ansa_pkg::REG_MANT_COUNT:  cnt_cfg_reg <= cfg_data[2:0];
                ansa_pkg::REG_MANT_SECOND: m2_reg <= cfg_data;
                ansa_pkg::REG_MANT_THIRD:  m3_reg <= cfg_data;
                ansa_pkg::REG_MANT_FOURTH: m4_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_FIN)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (diff < 0)
                        begin
                            lo_reg    <= in_b;
                            hi_reg    <= in_a;
                            width_reg <= VB'(-diff);
                        end
                        else
                        begin
                            lo_reg    <= in_a;
                            hi_reg    <= in_b;
                            width_reg <= VB'(diff);
                        end
                        req_reg   <= (in_data.requested_intervals == 10'd0) ? 10'd1
                                     : in_data.requested_intervals;
                        n_reg     <= 4'd0;
                        first_reg <= 1'b1;
                        if (diff == 0)
                        begin
                            res_reg.range_low      <= 32'(in_a);
                            res_reg.range_high     <= 32'(in_a);
                            res_reg.interval_count <= (in_data.requested_intervals == 10'd0)
                                                      ? 12'd1
                                                      : 12'(in_data.requested_intervals);
                            res_reg.step_mantissa  <= 4'd1;
                            res_reg.step_exponent  <= 4'd0;
                            res_reg.degenerate     <= 1'b1;
                            res_reg.step_floor_hit <= 1'b0;
                            state_reg <= S_FIN;
                        end
                        else
                            state_reg <= S_NSRCH;
                    end
                end
                S_NSRCH:
                begin
                    if (n_reg < 4'd9 &&
                        ansa_pkg::PROD_BITS'(ansa_pkg::pow10(n_reg + 4'd1)) <= width_x)
                        n_reg <= n_reg + 4'd1;
                    else
                    begin
                        idx_reg   <= last_idx;
                        state_reg <= S_ISRCH;
                    end
                end
                S_ISRCH:
                begin
                    if (idx_reg == 2'd0 || prod <= width_x)
                        state_reg <= S_STEP;
                    else
                        idx_reg <= idx_reg - 2'd1;
                end
                S_STEP:
                begin
                    step_reg  <= prod[VB-1:0];
                    pass_reg  <= 1'b0;
                    neg_reg   <= hi_reg[VB-1];
                    dvd_reg   <= hi_reg[VB-1] ? VB'(-hi_reg) : VB'(hi_reg);
                    rem_reg   <= '0;
                    cnt_reg   <= CW'(VB);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg <= qbit ? (rem_sh - {1'b0, step_reg}) : rem_sh;
                    dvd_reg <= {dvd_reg[VB-2:0], qbit};
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                        state_reg <= S_POST;
                end
                S_POST:
                begin
                    if (!pass_reg)
                    begin
                        flh_reg   <= neg_reg ? -(qx + rnz) : qx;
                        highv_reg <= VB'(xx - (neg_reg ? ((rnz != 0) ? sx - rx : EW'(0)) : rx));
                        pass_reg  <= 1'b1;
                        neg_reg   <= lo_reg[VB-1];
                        dvd_reg   <= lo_reg[VB-1] ? VB'(-lo_reg) : VB'(lo_reg);
                        rem_reg   <= '0;
                        cnt_reg   <= CW'(VB);
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        cll_reg   <= neg_reg ? -qx : qx + rnz;
                        lowv_reg  <= VB'(neg_reg ? xx + rx
                                         : xx + ((rnz != 0) ? sx - rx : EW'(0)));
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    res_reg.degenerate <= 1'b0;
                    if (ival >= reqx && !first_reg && (reqx - p_ival_reg) < (ival - reqx))
                    begin
                        res_reg.range_low      <= 32'(p_low_reg);
                        res_reg.range_high     <= 32'(p_high_reg);
                        res_reg.interval_count <= p_ival_reg[11:0];
                        res_reg.step_mantissa  <= p_mant_reg;
                        res_reg.step_exponent  <= p_n_reg;
                        res_reg.step_floor_hit <= 1'b0;
                        state_reg <= S_FIN;
                    end
                    else if (ival >= reqx || (idx_reg == 2'd0 && n_reg == 4'd0))
                    begin
                        res_reg.range_low      <= 32'(lowv_reg);
                        res_reg.range_high     <= 32'(highv_reg);
                        res_reg.interval_count <= ival[11:0];
                        res_reg.step_mantissa  <= mant;
                        res_reg.step_exponent  <= n_reg;
                        res_reg.step_floor_hit <= (ival < reqx);
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        p_low_reg  <= lowv_reg;
                        p_high_reg <= highv_reg;
                        p_ival_reg <= ival;
                        p_mant_reg <= mant;
                        p_n_reg    <= n_reg;
                        first_reg  <= 1'b0;
                        if (idx_reg == 2'd0)
                        begin
                            idx_reg <= last_idx;
                            n_reg   <= n_reg - 4'd1;
                        end
                        else
                            idx_reg <= idx_reg - 2'd1;
                        state_reg <= S_STEP;
                    end
                end
                default:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct {
        ansa_pkg::in_t  stim;
        bit             typed;
        ansa_pkg::out_t want;
    } row_t;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    ansa_pkg::in_t  in_data;
    logic           out_valid;
    logic           out_stall;
    ansa_pkg::out_t out_data;
    logic           cfg_we;
    logic [2:0]     cfg_index;
    logic [3:0]     cfg_data;

    logic [2:0] mant_count_q;
    logic [3:0] mant_second_q;
    logic [3:0] mant_third_q;
    logic [3:0] mant_fourth_q;

    ansa_pkg::out_t scale_exp_q[$];
    row_t rows[$];
    int   errors;
    bit   quiet;
    bit   hold_req;

    axis_nice_step_autoscaler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #50_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    function automatic longint ten_pow(int n);
        longint p;
        p = 1;
        for (int k = 0; k < n; k++)
            p = p * 10;
        return p;
    endfunction

    function automatic longint mant_of(int idx);
        logic [3:0] v;
        if (idx == 0)
            return 1;
        v = (idx == 1) ? mant_second_q : (idx == 2) ? mant_third_q : mant_fourth_q;
        return (v < 2) ? 2 : longint'(v);
    endfunction

    function automatic longint div_floor(longint num, longint d);
        if (num >= 0)
            return num / d;
        return -((-num + d - 1) / d);
    endfunction

    function automatic void place_step(longint lo, longint hi, longint step,
                                       output longint anc, output longint lft,
                                       output longint rgt);
        anc = -div_floor(-lo, step) * step;
        lft = div_floor(anc - lo, step);
        rgt = div_floor(hi - anc, step);
    endfunction

    function automatic ansa_pkg::out_t predict_scale(ansa_pkg::in_t x);
        longint lo, hi, req, width, step, anc, lft, rgt, ival;
        longint p_anc, p_lft, p_rgt, p_ival, t;
        int     used, idx, n, p_idx, p_n;
        bit     floor_hit;
        ansa_pkg::out_t r;
        lo = x.start_value;
        hi = x.stop_value;
        req = x.requested_intervals;
        floor_hit = 0;
        used = (mant_count_q < 1) ? 1 : (mant_count_q > 4) ? 4 : mant_count_q;
        if (lo > hi)
        begin
            t = lo;
            lo = hi;
            hi = t;
        end
        if (req < 1)
            req = 1;
        width = hi - lo;
        r = '0;
        if (width == 0)
        begin
            r.range_low = lo[31:0];
            r.range_high = hi[31:0];
            r.interval_count = req[11:0];
            r.step_mantissa = 4'd1;
            r.degenerate = 1'b1;
            return r;
        end
        n = 0;
        while (n < 9 && ten_pow(n + 1) <= width)
            n++;
        idx = 0;
        for (int i = used - 1; i >= 1; i--)
        begin
            if (mant_of(i) * ten_pow(n) <= width)
            begin
                idx = i;
                break;
            end
        end
        step = mant_of(idx) * ten_pow(n);
        place_step(lo, hi, step, anc, lft, rgt);
        ival = lft + rgt;
        while (ival < req)
        begin
            if (idx == 0 && n == 0)
            begin
                floor_hit = 1;
                break;
            end
            p_idx = idx; p_n = n; p_anc = anc; p_lft = lft; p_rgt = rgt; p_ival = ival;
            if (idx == 0)
            begin
                idx = used - 1;
                n--;
            end
            else
                idx--;
            step = mant_of(idx) * ten_pow(n);
            place_step(lo, hi, step, anc, lft, rgt);
            ival = lft + rgt;
            if (ival >= req)
            begin
                if ((req - p_ival) < (ival - req))
                begin
                    idx = p_idx; n = p_n; anc = p_anc; lft = p_lft; rgt = p_rgt;
                    ival = p_ival;
                    step = mant_of(idx) * ten_pow(n);
                end
                break;
            end
        end
        t = anc - lft * step;
        r.range_low = t[31:0];
        t = anc + rgt * step;
        r.range_high = t[31:0];
        r.interval_count = ival[11:0];
        r.step_mantissa = 4'(mant_of(idx));
        r.step_exponent = 4'(n);
        r.step_floor_hit = floor_hit;
        return r;
    endfunction

    task automatic write_reg(logic [2:0] index, logic [3:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_data = value;
        case (index)
            ansa_pkg::REG_MANT_COUNT:  mant_count_q = value[2:0];
            ansa_pkg::REG_MANT_SECOND: mant_second_q = value;
            ansa_pkg::REG_MANT_THIRD:  mant_third_q = value;
            ansa_pkg::REG_MANT_FOURTH: mant_fourth_q = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_range(ansa_pkg::in_t x, bit typed, ansa_pkg::out_t want);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = x;
        do
            @(posedge clk);
        while (in_stall);
        scale_exp_q.push_back(typed ? want : predict_scale(x));
        @(negedge clk);
    endtask

    task automatic drain;
        @(negedge clk);
        in_valid = 1'b0;
        while (scale_exp_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic ansa_pkg::in_t rand_range();
        ansa_pkg::in_t x;
        longint a;
        x.start_value = $urandom;
        case ($urandom_range(0, 9))
            0: x.stop_value = $urandom;
            1: x.stop_value = x.start_value;
            default:
            begin
                a = longint'(x.start_value) + ($urandom_range(1, 1 << $urandom_range(0, 20)));
                x.stop_value = a[31:0];
                if ($urandom_range(0, 1))
                begin
                    x.stop_value = x.start_value;
                    x.start_value = a[31:0];
                end
            end
        endcase
        x.requested_intervals = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, 24))
                                                           : 10'($urandom_range(0, 1023));
        return x;
    endfunction

    task automatic random_phase(int count);
        for (int k = 0; k < count; k++)
            send_range(rand_range(), 1'b0, '0);
        drain();
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall = 1'b1;
                repeat (3000) @(negedge clk);
                out_stall = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 19) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        ansa_pkg::out_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (scale_exp_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transfer %p", out_data);
            end
            else
            begin
                w = scale_exp_q.pop_front();
                if (out_data.range_low !== w.range_low
                    || out_data.range_high !== w.range_high
                    || out_data.interval_count !== w.interval_count
                    || out_data.step_mantissa !== w.step_mantissa
                    || out_data.step_exponent !== w.step_exponent
                    || out_data.degenerate !== w.degenerate
                    || out_data.step_floor_hit !== w.step_floor_hit)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp %p got %p", w, out_data);
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        quiet = 0;
        hold_req = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mant_count_q = 3'd3;
        mant_second_q = 4'd2;
        mant_third_q = 4'd5;
        mant_fourth_q = 4'd9;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero width, request below one, step floor, extremes
        rows.push_back('{'{5, 5, 0}, 1, '{5, 5, 1, 1, 0, 1, 0}});
        rows.push_back('{'{32'h8000_0000, 32'h8000_0000, 1023}, 1,
                         '{32'h8000_0000, 32'h8000_0000, 1023, 1, 0, 1, 0}});
        rows.push_back('{'{32'h7fff_ffff, 32'h7fff_ffff, 512}, 1,
                         '{32'h7fff_ffff, 32'h7fff_ffff, 512, 1, 0, 1, 0}});
        rows.push_back('{'{0, 1, 5}, 1, '{0, 1, 1, 1, 0, 0, 1}});
        rows.push_back('{'{1, 0, 0}, 1, '{0, 1, 1, 1, 0, 0, 0}});
        rows.push_back('{'{32'h8000_0000, 32'h7fff_ffff, 1023}, 0, '0});
        rows.push_back('{'{32'h7fff_ffff, 32'h8000_0000, 0}, 0, '0});
        rows.push_back('{'{32'h8000_0000, 32'h7fff_ffff, 1}, 0, '0});
        rows.push_back('{'{0, 100, 10}, 0, '0});
        rows.push_back('{'{-17, 83, 7}, 0, '0});
        rows.push_back('{'{1000, -3, 3}, 0, '0});
        rows.push_back('{'{3, 97, 4}, 0, '0});
        rows.push_back('{'{-999, -1, 1023}, 0, '0});
        rows.push_back('{'{12345, 678901, 6}, 0, '0});
        for (int k = 0; k < rows.size(); k++)
            send_range(rows[k].stim, rows[k].typed, rows[k].want);
        drain();

        write_reg(ansa_pkg::REG_MANT_COUNT, 4'd1);
        write_reg(ansa_pkg::REG_MANT_SECOND, 4'd0);
        write_reg(ansa_pkg::REG_MANT_THIRD, 4'd1);
        write_reg(ansa_pkg::REG_MANT_FOURTH, 4'd15);
        random_phase(60);

        write_reg(ansa_pkg::REG_MANT_COUNT, 4'd4);
        write_reg(ansa_pkg::REG_MANT_SECOND, 4'd2);
        write_reg(ansa_pkg::REG_MANT_THIRD, 4'd5);
        write_reg(ansa_pkg::REG_MANT_FOURTH, 4'd9);
        hold_req = 1'b1;
        random_phase(60);

        write_reg(ansa_pkg::REG_MANT_COUNT, 4'd7);
        write_reg(ansa_pkg::REG_MANT_SECOND, 4'd9);
        write_reg(ansa_pkg::REG_MANT_THIRD, 4'd3);
        write_reg(ansa_pkg::REG_MANT_FOURTH, 4'd1);
        write_reg(REG_UNUSED, 4'd15);
        random_phase(60);

        write_reg(ansa_pkg::REG_MANT_COUNT, 4'd0);
        write_reg(ansa_pkg::REG_MANT_SECOND, 4'd15);
        random_phase(50);

        write_reg(ansa_pkg::REG_MANT_COUNT, 4'($urandom_range(2, 4)));
        write_reg(ansa_pkg::REG_MANT_SECOND, 4'($urandom_range(2, 4)));
        write_reg(ansa_pkg::REG_MANT_THIRD, 4'($urandom_range(5, 7)));
        write_reg(ansa_pkg::REG_MANT_FOURTH, 4'($urandom_range(8, 9)));
        quiet = 1'b1;
        random_phase(60);

        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ansa_pkg.sv
rtl/axis_nice_step_autoscaler.sv
test/tb_top.sv
